// ===== hdl/ngh_pkg.sv =====
// ----------------------------------------------------------------------------
// ngh_pkg
// shared types and constants of the n-gram multiply-xor hash block
// ----------------------------------------------------------------------------
package ngh_pkg;

  localparam int TOKEN_W = 32;
  localparam int MULT_W  = 64;
  localparam int MOD_W   = 32;
  localparam int HEAD_W  = 2;
  localparam int CFG_IDX_W  = 64;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_HEADS  = 4;
  localparam int REM_CNT_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_ID   = 64'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_0   = 64'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_1   = 64'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_2   = 64'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_BI_0 = 64'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_BI_1 = 64'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_TRI_0 = 64'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_TRI_1 = 64'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_REM,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture word, update history
    logic mul_step;  // one partial product step
    logic mix;       // form mixes
    logic rem_start; // start remainder for current head
    logic rem_step;  // one remainder bit
    logic out_load;  // move result to output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic rem_done;
  } dp_sts_t;

endpackage

// ===== hdl/ngh_if.sv =====
// ----------------------------------------------------------------------------
// ngh_in_if / ngh_out_if
// valid-ready channels of the hash block
// ----------------------------------------------------------------------------
interface ngh_in_if;
  import ngh_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token;
  logic               row_start;
  modport source (output valid, output token, output row_start, input ready);
  modport sink (input valid, input token, input row_start, output ready);
endinterface

interface ngh_out_if;
  import ngh_pkg::*;
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] head_index;
  logic [MOD_W-1:0]  hash_value;
  logic              last;
  modport source (output valid, output head_index, output hash_value, output last,
                  input ready);
  modport sink (input valid, input head_index, input hash_value, input last,
                output ready);
endinterface

// ===== hdl/ngh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngh_ctrl
// sequencer: multiply, mix, one bit-serial remainder per head, output
// ----------------------------------------------------------------------------
module ngh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       head,
  output logic             last,
  output ngh_pkg::dp_cmd_t cmd,
  input  ngh_pkg::dp_sts_t sts
);
  import ngh_pkg::*;

  state_t state_r, state_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic ov_r, ov_nxt;
  logic [HEAD_W-1:0] ohead_r, ohead_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      ov_r    <= 1'b0;
      ohead_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      ov_r    <= ov_nxt;
      ohead_r <= ohead_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign head      = head_r;
  assign last      = (ohead_r == HEAD_W'(NUM_HEADS - 1));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    ohead_nxt = ohead_r;
    ov_nxt    = ov_r & ~out_ready;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          head_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix       = 1'b1;
        state_nxt     = ST_REM;
      end
      ST_REM: begin
        if (!sts.rem_done) begin
          cmd.rem_step = 1'b1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          ohead_nxt    = head_r;
          if (head_r == HEAD_W'(NUM_HEADS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            head_nxt      = head_r + 1'b1;
            cmd.rem_start = 1'b1;
            state_nxt     = ST_REM;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_MIX) cmd.rem_start = 1'b1;
  end
endmodule

// ===== hdl/ngh_dp.sv =====
// ----------------------------------------------------------------------------
// ngh_dp
// config registers, history, 32x32 partial product multiplier, mixes,
// restoring bit-serial floor remainder
// ----------------------------------------------------------------------------
module ngh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ngh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ngh_pkg::TOKEN_W-1:0]   in_token,
  input  logic                          in_row_start,
  input  logic [1:0]                    head,
  input  ngh_pkg::dp_cmd_t              cmd,
  output ngh_pkg::dp_sts_t              sts,
  output logic [ngh_pkg::MOD_W-1:0]     hash_value
);
  import ngh_pkg::*;

  logic [TOKEN_W-1:0] pad_r;
  logic [MULT_W-1:0]  mult_r [3];
  logic [MOD_W-1:0]   mod_r [4];
  logic [TOKEN_W-1:0] hist_r [2];
  logic [TOKEN_W-1:0] tok_r [3];
  logic [MULT_W-1:0]  prod_r [3];
  logic [2:0]         mstep_r;
  logic [MULT_W-1:0]  mix2_r, mix3_r;
  logic [MULT_W-1:0]  mag_r;
  logic               neg_r;
  logic [MOD_W:0]     rem_r;
  logic [REM_CNT_W-1:0] cnt_r;
  logic [MOD_W-1:0]   hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r <= '0;
      for (int i = 0; i < 3; i++) mult_r[i] <= 64'd1;
      for (int i = 0; i < 4; i++) mod_r[i] <= 32'd1;
      hist_r[0] <= '0;
      hist_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PAD_ID:    pad_r     <= cfg_data[TOKEN_W-1:0];
          REG_MULT_0:    mult_r[0] <= cfg_data;
          REG_MULT_1:    mult_r[1] <= cfg_data;
          REG_MULT_2:    mult_r[2] <= cfg_data;
          REG_MOD_BI_0:  mod_r[0]  <= cfg_data[MOD_W-1:0];
          REG_MOD_BI_1:  mod_r[1]  <= cfg_data[MOD_W-1:0];
          REG_MOD_TRI_0: mod_r[2]  <= cfg_data[MOD_W-1:0];
          REG_MOD_TRI_1: mod_r[3]  <= cfg_data[MOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        hist_r[0] <= in_token;
        hist_r[1] <= in_row_start ? pad_r : hist_r[0];
      end
    end
  end

  // one 32x32 partial product per step: 3 tokens x 2 multiplier halves
  logic [1:0] ti;
  logic       hi;
  logic [63:0] pp;
  assign ti = (mstep_r[2:1] == 2'd3) ? 2'd2 : mstep_r[2:1];
  assign hi = mstep_r[0];
  assign pp = tok_r[ti] * (hi ? mult_r[ti][63:32] : mult_r[ti][31:0]);
  assign sts.mul_done = (mstep_r == 3'd5);

  // remainder: shift magnitude bits into rem, subtract modulus
  logic [MOD_W-1:0] m;
  logic [MOD_W:0]   sh, dif;
  assign m   = mod_r[head];
  assign sh  = {rem_r[MOD_W-1:0], mag_r[MULT_W-1]};
  assign dif = sh - {1'b0, m};
  assign sts.rem_done = (cnt_r == REM_CNT_W'(MULT_W));

  // head still holds the finished head; every head after head 0 takes mix3
  // except head 1, i.e. next head uses mix3 when the finished head is not 0
  logic nxt_tri;
  assign nxt_tri = (head != 2'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_r[0] <= in_token;
      tok_r[1] <= in_row_start ? pad_r : hist_r[0];
      tok_r[2] <= in_row_start ? pad_r : hist_r[1];
      mstep_r  <= '0;
    end
    if (cmd.mul_step) begin
      if (hi) prod_r[ti] <= prod_r[ti] + {pp[31:0], 32'd0};
      else    prod_r[ti] <= pp;
      mstep_r <= mstep_r + 1'b1;
    end
    if (cmd.mix) begin
      mix2_r <= prod_r[0] ^ prod_r[1];
      mix3_r <= prod_r[0] ^ prod_r[1] ^ prod_r[2];
    end
    if (cmd.rem_start) begin
      // head selects mix; at mix time head is 0 so mix2 is forwarded
      if (cmd.mix) begin
        neg_r <= prod_r[0][63] ^ prod_r[1][63];
        mag_r <= (prod_r[0][63] ^ prod_r[1][63]) ? -(prod_r[0] ^ prod_r[1])
                                                 : (prod_r[0] ^ prod_r[1]);
      end else begin
        neg_r <= (nxt_tri ? mix3_r[63] : mix2_r[63]);
        mag_r <= (nxt_tri ? mix3_r[63] : mix2_r[63]) ?
                 -(nxt_tri ? mix3_r : mix2_r) : (nxt_tri ? mix3_r : mix2_r);
      end
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.rem_step) begin
      rem_r <= dif[MOD_W] ? sh : dif;
      mag_r <= {mag_r[MULT_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      if (m == '0 || rem_r == '0) hash_r <= '0;
      else if (neg_r)             hash_r <= m - rem_r[MOD_W-1:0];
      else                        hash_r <= rem_r[MOD_W-1:0];
    end
  end

  assign hash_value = hash_r;
endmodule

// ===== hdl/ngram_multiply_xor_hash_core.sv =====
// ----------------------------------------------------------------------------
// ngram_multiply_xor_hash_core
// bigram and trigram multiply-xor hashes reduced by four head moduli
// ----------------------------------------------------------------------------
// operation: six multiply steps and a mix step, then per head a 64-step
//   bit-serial remainder, a done check and an output step; a new word is
//   accepted only after the last head's result is loaded; result stalls hold the output step
// reset: synchronous active low; config registers, history and control state return to defaults
module ngram_multiply_xor_hash_core (
  input  logic                           clk,
  input  logic                           rst_n,
  ngh_in_if.sink                         in_ch,
  ngh_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ngh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ngh_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [1:0] head;
  logic [HEAD_W-1:0] ohead_r;

  ngh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .head(head), .last(out_ch.last), .cmd(cmd), .sts(sts)
  );

  ngh_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_token(in_ch.token), .in_row_start(in_ch.row_start),
    .head(head), .cmd(cmd), .sts(sts), .hash_value(out_ch.hash_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ohead_r <= '0;
    end else if (cmd.out_load) begin
      ohead_r <= head;
    end
  end
  assign out_ch.head_index = ohead_r;
endmodule

// ===== hdl/ngh_checker.sv =====
// ----------------------------------------------------------------------------
// ngh_checker
// port-level checks of the hash block
// ----------------------------------------------------------------------------
module ngh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_head,
  input logic       out_last
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_head == 2'd3)))
    else $error("last flag mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head))
    else $error("stalled word changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken mid token");
endmodule

bind ngram_multiply_xor_hash_core ngh_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_head(out_ch.head_index), .out_last(out_ch.last)
);
